>>> design/assert_macros.svh
// Assertion helpers, included by the design file range_decoder_raw_bits.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RDRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RDRB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define RDRB_ASSERT(lbl, prop, msg)
`define RDRB_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> design/rdrb_pkg.sv
package rdrb_pkg;

  localparam int unsigned RENORM_LIMIT_LOG2 = 24;
  localparam logic [31:0] RENORM_LIMIT = 32'd1 << RENORM_LIMIT_LOG2;

  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_IDLE   = 4'd0;
  localparam pc_t STEP_MODE   = 4'd1;
  localparam pc_t STEP_ZERO   = 4'd2;
  localparam pc_t STEP_SHIFT  = 4'd3;
  localparam pc_t STEP_DIVSET = 4'd4;
  localparam pc_t STEP_DIV    = 4'd5;
  localparam pc_t STEP_FOLD   = 4'd6;
  localparam pc_t STEP_RENORM = 4'd7;
  localparam pc_t STEP_NEXT   = 4'd8;
  localparam pc_t STEP_INIT   = 4'd9;
  localparam pc_t STEP_EMIT   = 4'd10;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SHIFT,
    OP_DIVSET,
    OP_DIV,
    OP_FOLD,
    OP_RENORM,
    OP_NEXT,
    OP_INIT,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_NO_REQ,
    C_INIT,
    C_ZERO_BITS,
    C_LEN_ZERO,
    C_DIV_BUSY,
    C_NO_RENORM,
    C_RENORM_MORE,
    C_SECOND,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   jump;
    pc_t   next;
  } ctl_word_t;

  function automatic ctl_word_t ucode_rom(pc_t pc);
    ctl_word_t w;
    w = '{op: OP_NOP, cond: C_NEVER, jump: STEP_IDLE, next: STEP_IDLE};
    case (pc)
      STEP_IDLE:   w = '{op: OP_ACCEPT, cond: C_NO_REQ,      jump: STEP_IDLE,
                         next: STEP_MODE};
      STEP_MODE:   w = '{op: OP_NOP,    cond: C_INIT,        jump: STEP_INIT,
                         next: STEP_ZERO};
      STEP_ZERO:   w = '{op: OP_NOP,    cond: C_ZERO_BITS,   jump: STEP_EMIT,
                         next: STEP_SHIFT};
      STEP_SHIFT:  w = '{op: OP_SHIFT,  cond: C_NEVER,       jump: STEP_IDLE,
                         next: STEP_DIVSET};
      STEP_DIVSET: w = '{op: OP_DIVSET, cond: C_LEN_ZERO,    jump: STEP_FOLD,
                         next: STEP_DIV};
      STEP_DIV:    w = '{op: OP_DIV,    cond: C_DIV_BUSY,    jump: STEP_DIV,
                         next: STEP_FOLD};
      STEP_FOLD:   w = '{op: OP_FOLD,   cond: C_NO_RENORM,   jump: STEP_NEXT,
                         next: STEP_RENORM};
      STEP_RENORM: w = '{op: OP_RENORM, cond: C_RENORM_MORE, jump: STEP_RENORM,
                         next: STEP_NEXT};
      STEP_NEXT:   w = '{op: OP_NEXT,   cond: C_SECOND,      jump: STEP_SHIFT,
                         next: STEP_EMIT};
      STEP_INIT:   w = '{op: OP_INIT,   cond: C_NEVER,       jump: STEP_IDLE,
                         next: STEP_EMIT};
      STEP_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,    jump: STEP_EMIT,
                         next: STEP_IDLE};
      default:     w = '{op: OP_NOP,    cond: C_NEVER,       jump: STEP_IDLE,
                         next: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> design/range_decoder_raw_bits.sv
// Range decoder for equiprobable raw bit fields.
// Input channel (in_valid_i / in_ready_o) carries mode_i, bit_count_i and four
// lookahead stream bytes in next_bytes_i, earliest byte in bits 31..24.
// mode_i = 0 loads the code value from the four bytes; mode_i = 1 reads
// bit_count_i raw bits (1..32, larger counts act as 32, zero decodes nothing).
// Output channel (out_valid_o / out_ready_i) returns one result per request:
// decoded_value_o, bytes_used_o (lookahead bytes consumed, the caller advances
// its stream by that much) and range_error_o for a corrupt stream.
// One request is processed at a time by a microcoded sequencer.
// Steps: an init request loads the code value; a read shifts the length, divides
// the code value by it in a restoring divider, one quotient bit per cycle and
// step, then renormalizes while the length is low, pulling one lookahead byte per
// step. A read of 20 to 32 bits runs this twice, 16 low bits then the rest, and
// the high half takes one step without a pull when the lookahead is spent (0..5
// renormalization steps in all); a zero length skips the divide.
// in_ready_o is high only while the sequencer waits for a request, so the next
// request is taken while an earlier result still waits in the output register.
// When the receiver stalls, the result holds and the sequencer waits at its
// final step. Reset clears the code value to zero and the length to all ones.
`include "assert_macros.svh"

module range_decoder_raw_bits (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [5:0]  bit_count_i,
  input  logic [31:0] next_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] decoded_value_o,
  output logic [2:0]  bytes_used_o,
  output logic        range_error_o
);

  rdrb_pkg::pc_t       pc_q, pc_d;
  rdrb_pkg::ctl_word_t ctl;

  logic [31:0] code_q, code_d;
  logic [31:0] len_q, len_d;
  logic [31:0] look_q, look_d;
  logic        mode_q, mode_d;
  logic [5:0]  bits_q, bits_d;
  logic [4:0]  w_q, w_d;
  logic        two_q, two_d;
  logic        phase_q, phase_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [2:0]  used_q, used_d;
  logic        err_q, err_d;
  logic [31:0] res_q, res_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_val_q, out_val_d;
  logic [2:0]  out_used_q, out_used_d;
  logic        out_err_q, out_err_d;

  logic [5:0]  bits_eff;
  logic [32:0] trial;
  logic        trial_ge;
  logic [31:0] rem_next;
  logic [31:0] mask;
  logic [31:0] q_cut;
  logic [4:0]  byte_sh;
  logic [7:0]  nbyte;
  logic [31:0] len_sh8;
  logic        out_free;
  logic        cond_hit;

  assign ctl      = rdrb_pkg::ucode_rom(pc_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign bits_eff = (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;
  assign trial    = {rem_q, quo_q[31]} - {1'b0, len_q};
  assign trial_ge = !trial[32];
  assign rem_next = trial_ge ? trial[31:0] : {rem_q[30:0], quo_q[31]};
  assign mask     = (32'd1 << w_q) - 32'd1;
  assign q_cut    = quo_q & mask;
  assign byte_sh  = 5'd24 - {used_q[1:0], 3'b000};
  assign nbyte    = 8'(look_q >> byte_sh);
  assign len_sh8  = len_q << 8;

  always_comb begin
    case (ctl.cond)
      rdrb_pkg::C_NEVER:       cond_hit = 1'b0;
      rdrb_pkg::C_NO_REQ:      cond_hit = !in_valid_i;
      rdrb_pkg::C_INIT:        cond_hit = !mode_q;
      rdrb_pkg::C_ZERO_BITS:   cond_hit = (bits_q == 6'd0);
      rdrb_pkg::C_LEN_ZERO:    cond_hit = (len_q == 32'd0);
      rdrb_pkg::C_DIV_BUSY:    cond_hit = (cnt_q != 5'd31);
      rdrb_pkg::C_NO_RENORM:   cond_hit = (len_q >= rdrb_pkg::RENORM_LIMIT);
      rdrb_pkg::C_RENORM_MORE: cond_hit = (used_q < 3'd3) &&
                                          (len_sh8 < rdrb_pkg::RENORM_LIMIT);
      rdrb_pkg::C_SECOND:      cond_hit = two_q && !phase_q;
      rdrb_pkg::C_OUT_BUSY:    cond_hit = !out_free;
      default:                 cond_hit = 1'b0;
    endcase
  end

  assign pc_d       = cond_hit ? ctl.jump : ctl.next;
  assign in_ready_o = (ctl.op == rdrb_pkg::OP_ACCEPT);

  always_comb begin
    code_d      = code_q;
    len_d       = len_q;
    look_d      = look_q;
    mode_d      = mode_q;
    bits_d      = bits_q;
    w_d         = w_q;
    two_d       = two_q;
    phase_d     = phase_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    err_d       = err_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_used_d  = out_used_q;
    out_err_d   = out_err_q;
    case (ctl.op)
      rdrb_pkg::OP_ACCEPT: begin
        if (in_valid_i) begin
          look_d  = next_bytes_i;
          mode_d  = mode_i;
          bits_d  = bits_eff;
          two_d   = (bits_eff > 6'd19);
          w_d     = (bits_eff > 6'd19) ? 5'd16 : bits_eff[4:0];
          phase_d = 1'b0;
          used_d  = 3'd0;
          err_d   = 1'b0;
          res_d   = 32'd0;
        end
      end
      rdrb_pkg::OP_SHIFT: begin
        len_d = len_q >> w_q;
      end
      rdrb_pkg::OP_DIVSET: begin
        rem_d = 32'd0;
        cnt_d = 5'd0;
        quo_d = (len_q == 32'd0) ? 32'hFFFF_FFFF : code_q;
      end
      rdrb_pkg::OP_DIV: begin
        rem_d = rem_next;
        quo_d = {quo_q[30:0], trial_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          code_d = rem_next;
        end
      end
      rdrb_pkg::OP_FOLD: begin
        if ((quo_q >> w_q) != 32'd0) begin
          err_d = 1'b1;
        end
        res_d = phase_q ? (res_q | (q_cut << 16)) : q_cut;
      end
      rdrb_pkg::OP_RENORM: begin
        if (used_q < 3'd4) begin
          code_d = {code_q[23:0], nbyte};
          len_d  = len_sh8;
          used_d = used_q + 3'd1;
        end
      end
      rdrb_pkg::OP_NEXT: begin
        if (two_q && !phase_q) begin
          phase_d = 1'b1;
          w_d     = 5'(bits_q - 6'd16);
        end
      end
      rdrb_pkg::OP_INIT: begin
        code_d = look_q;
        len_d  = 32'hFFFF_FFFF;
        used_d = 3'd4;
        res_d  = 32'd0;
        err_d  = 1'b0;
      end
      rdrb_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = res_q;
          out_used_d  = used_q;
          out_err_d   = err_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= rdrb_pkg::STEP_IDLE;
      code_q      <= 32'd0;
      len_q       <= 32'hFFFF_FFFF;
      out_valid_q <= 1'b0;
      used_q      <= 3'd0;
      cnt_q       <= 5'd0;
      phase_q     <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      code_q      <= code_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    look_q     <= look_d;
    mode_q     <= mode_d;
    bits_q     <= bits_d;
    w_q        <= w_d;
    two_q      <= two_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    err_q      <= err_d;
    res_q      <= res_d;
    out_val_q  <= out_val_d;
    out_used_q <= out_used_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_value_o = out_val_q;
  assign bytes_used_o    = out_used_q;
  assign range_error_o   = out_err_q;

  `RDRB_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "ready after request")
  `RDRB_ASSERT(a_used_range, used_q <= 3'd4, "lookahead count above four")
  `RDRB_ASSERT_NEXT(a_div_count, ctl.op == rdrb_pkg::OP_DIV && cnt_q != 5'd31, cnt_q == $past(cnt_q) + 5'd1, "divider count skipped")
  `RDRB_ASSERT(a_emit_only, $rose(out_valid_o) |-> $past(ctl.op == rdrb_pkg::OP_EMIT), "result outside emit step")
  `RDRB_ASSERT(a_init_used, (ctl.op == rdrb_pkg::OP_INIT) |-> (used_q == 3'd0), "init with bytes used")

endmodule

>>> sim/decode_req_pkg.sv
`timescale 1ns / 100ps
package decode_req_pkg;

  typedef enum logic {
    MODE_INIT = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

endpackage

>>> sim/rdrb_checker.sv
`timescale 1ns / 100ps
module rdrb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        mode_i,
  input  logic [5:0]  bit_count_i,
  input  logic [31:0] next_bytes_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] decoded_value_i,
  input  logic [2:0]  bytes_used_i,
  input  logic        range_error_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  used;
    logic        err;
  } decode_result_t;

  decode_result_t expected_results[$];

  logic [31:0] code_q;
  logic [31:0] length_q;
  logic [31:0] look_q;
  int unsigned used_q;
  logic        err_q;

  function automatic void pull_bytes();
    logic more;
    more = 1'b1;
    while (more && used_q < 4) begin
      code_q = (code_q << 8) | ((look_q >> (24 - 8 * used_q)) & 32'hFF);
      used_q++;
      length_q = length_q << 8;
      more = length_q < rdrb_pkg::RENORM_LIMIT;
    end
  endfunction

  function automatic logic [31:0] div_step(input int unsigned width);
    logic [31:0] quot;
    length_q = length_q >> width;
    if (length_q == '0) begin
      quot = '1;
    end else begin
      quot = code_q / length_q;
      code_q = code_q - length_q * quot;
    end
    if (length_q < rdrb_pkg::RENORM_LIMIT) pull_bytes();
    if ((quot >> width) != 0) err_q = 1'b1;
    return quot & ((32'd1 << width) - 32'd1);
  endfunction

  function automatic decode_result_t decode_request(input logic mode, input logic [5:0] bits,
                                                    input logic [31:0] look);
    decode_result_t res;
    int unsigned count;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] value;
    look_q = look;
    used_q = 0;
    err_q = 1'b0;
    value = '0;
    count = bits;
    if (decode_req_pkg::mode_e'(mode) == decode_req_pkg::MODE_INIT) begin
      code_q = look;
      length_q = '1;
      used_q = 4;
    end else if (count != 0) begin
      if (count > 32) count = 32;
      if (count > 19) begin
        lo = div_step(16);
        hi = div_step(count - 16);
        value = (hi << 16) | lo;
      end else begin
        value = div_step(count);
      end
    end
    res.value = value;
    res.used = used_q[2:0];
    res.err = err_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decode_result_t want;
    if (!rst_ni) begin
      code_q = '0;
      length_q = '1;
      expected_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: decoded_value %h", decoded_value_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (decoded_value_i !== want.value) begin
            $error("decoded_value mismatch: expected %h, actual %h", want.value,
                   decoded_value_i);
            fail_count_o++;
          end
          if (bytes_used_i !== want.used) begin
            $error("bytes_used mismatch: expected %0d, actual %0d", want.used, bytes_used_i);
            fail_count_o++;
          end
          if (range_error_i !== want.err) begin
            $error("range_error mismatch: expected %b, actual %b", want.err, range_error_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(decode_request(mode_i, bit_count_i, next_bytes_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned NUM_CHUNKS = 8;
  localparam int unsigned CHUNK_ITEMS = 206;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = 1'b0;
  logic [5:0]  bit_count_i = '0;
  logic [31:0] next_bytes_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] decoded_value_o;
  logic [2:0]  bytes_used_o;
  logic        range_error_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned idle_cycles = 0;

  range_decoder_raw_bits dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .bit_count_i    (bit_count_i),
    .next_bytes_i   (next_bytes_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .decoded_value_o(decoded_value_o),
    .bytes_used_o   (bytes_used_o),
    .range_error_o  (range_error_o)
  );

  rdrb_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .mode_i         (mode_i),
    .bit_count_i    (bit_count_i),
    .next_bytes_i   (next_bytes_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .decoded_value_i(decoded_value_o),
    .bytes_used_i   (bytes_used_o),
    .range_error_i  (range_error_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input decode_req_pkg::mode_e mode, input logic [5:0] bits,
                          input logic [31:0] bytes);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    bit_count_i <= bits;
    next_bytes_i <= bytes;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic random_request();
    int unsigned roll;
    int unsigned pick;
    logic [5:0]  bits;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    bits = 6'($urandom);
    if (roll < 6) begin
      send_req(decode_req_pkg::MODE_INIT, bits, $urandom);
    end else if (roll < 8) begin
      send_req(decode_req_pkg::MODE_INIT, bits, 32'hFFF0_0000 | $urandom);
    end else begin
      if (pick < 84) bits = 6'($urandom_range(1, 32));
      else if (pick < 89) bits = '0;
      else if (pick < 94) bits = 6'($urandom_range(33, 63));
      else if (pick < 96) bits = 6'd19;
      else if (pick < 98) bits = 6'd20;
      else bits = 6'd32;
      send_req(decode_req_pkg::MODE_READ, bits, $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_req(decode_req_pkg::MODE_READ, 6'd1, 32'hA5A5_A5A5);
    send_req(decode_req_pkg::MODE_READ, 6'd0, 32'hFFFF_FFFF);
    send_req(decode_req_pkg::MODE_INIT, 6'd63, 32'hFFFF_FFFF);
    send_req(decode_req_pkg::MODE_READ, 6'd32, 32'h0000_0000);
    send_req(decode_req_pkg::MODE_INIT, 6'd0, 32'h0000_0000);
    send_req(decode_req_pkg::MODE_READ, 6'd19, 32'hFFFF_FFFF);
    send_req(decode_req_pkg::MODE_READ, 6'd20, 32'h0000_0000);
    send_req(decode_req_pkg::MODE_READ, 6'd32, 32'hFFFF_FFFF);
    send_req(decode_req_pkg::MODE_READ, 6'd33, 32'h1234_5678);
    send_req(decode_req_pkg::MODE_READ, 6'd63, 32'h0000_0000);
    send_req(decode_req_pkg::MODE_INIT, 6'd8, 32'h1234_5678);
    repeat (4) send_req(decode_req_pkg::MODE_READ, 6'd8, $urandom);
    send_req(decode_req_pkg::MODE_READ, 6'd1, $urandom);
    send_req(decode_req_pkg::MODE_INIT, 6'd1, 32'h8000_0000);
    send_req(decode_req_pkg::MODE_READ, 6'd1, 32'h5A5A_5A5A);
    send_req(decode_req_pkg::MODE_READ, 6'd16, 32'hC3C3_C3C3);
    send_req(decode_req_pkg::MODE_READ, 6'd17, 32'h3C3C_3C3C);
    send_req(decode_req_pkg::MODE_INIT, 6'd2, 32'hFFFF_FF00);
    send_req(decode_req_pkg::MODE_READ, 6'd2, 32'h0000_0000);
    send_req(decode_req_pkg::MODE_INIT, 6'd32, 32'hDEAD_BEEF);
    send_req(decode_req_pkg::MODE_READ, 6'd32, 32'hFFFF_FFFF);
    send_req(decode_req_pkg::MODE_READ, 6'd32, 32'h0000_0000);
    send_req(decode_req_pkg::MODE_READ, 6'd0, $urandom);

    for (int unsigned chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      drain_requests();
      case (chunk % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 88;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 88;
        end
        default: begin
          idle_pct = 9;
          stall_pct = 9;
        end
      endcase
      for (int unsigned n = 0; n < CHUNK_ITEMS; n++) random_request();
    end

    drain_requests();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/rdrb_pkg.sv
design/range_decoder_raw_bits.sv
sim/decode_req_pkg.sv
sim/rdrb_checker.sv
sim/tb_top.sv
